@@ hdl/sdwv_pkg.sv @@
package sdwv_pkg;

  // CORDIC datapath: vectors in signed Q28 with headroom for the CORDIC gain.
  localparam int CordicSteps = 24;
  localparam int StepW = 5;
  localparam int VecW = 34;
  localparam int AngW = 34;
  localparam logic [29:0] CordicGain = 30'd652032874;

  // Divider for the ramp: signed dividend, 8-bit unsigned divisor.
  localparam int DivW = 40;
  localparam int DivCntW = 6;

  // Configuration register indexes.
  localparam logic [2:0] RegDriveTurnRatio = 3'd0;
  localparam logic [2:0] RegCoastFactor = 3'd1;
  localparam logic [2:0] RegDeadBand = 3'd2;
  localparam logic [2:0] RegRobotFrame = 3'd3;
  localparam logic [2:0] RegPostClamp = 3'd4;

  localparam logic [15:0] DriveTurnRatioRst = 16'd45875;
  localparam logic [7:0] CoastFactorRst = 8'd15;
  localparam logic [14:0] DeadBandRst = 15'd1638;

  typedef struct packed {
    logic start;
    logic vec_mode;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [15:0] ang;
  } cordic_req_t;

  typedef struct packed {
    logic start;
    logic signed [DivW-1:0] num;
    logic [7:0] den;
  } div_req_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic signed [AngW-1:0] atan_entry(input logic [StepW-1:0] i);
    logic signed [AngW-1:0] v;
    unique case (i)
      5'd0: v = 34'sd536870912;
      5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;
      5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;
      5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10679838;
      5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;
      5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Turn direction of each wheel: FL, FR, BL, BR.
  function automatic logic [15:0] wheel_angle(input logic [1:0] k);
    logic [15:0] v;
    unique case (k)
      2'd0: v = 16'h2000;
      2'd1: v = 16'h6000;
      2'd2: v = 16'hE000;
      2'd3: v = 16'hA000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/sdwv_cordic.sv @@
module sdwv_cordic import sdwv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cordic_req_t            req,
  output logic                   done,
  output logic signed [VecW-1:0] x_out,
  output logic signed [VecW-1:0] y_out,
  output logic [15:0]            ang_out
);

  logic signed [VecW-1:0] x, y, xs, ys;
  logic signed [AngW-1:0] z, at, zr;
  logic [StepW-1:0] step;
  logic running, mode, zero_vec, up, flip;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = atan_entry(step);
  assign up = mode ? !(y > 0) : (z >= 0);
  assign flip = req.ang[15] ^ req.ang[14];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step <= '0;
        mode <= req.vec_mode;
        if (req.vec_mode) begin
          zero_vec <= (req.x == 0) && (req.y == 0);
          if (req.x < 0) begin
            x <= -req.x;
            y <= -req.y;
            z <= 34'sh0_8000_0000;
          end else begin
            x <= req.x;
            y <= req.y;
            z <= '0;
          end
        end else begin
          zero_vec <= 1'b0;
          // Fold the left half plane onto the right half by a half turn.
          x <= flip ? -req.x : req.x;
          y <= '0;
          z <= AngW'($signed({~req.ang[15] ^ ~flip, req.ang[14:0], 16'h0000}));
        end
      end else if (running) begin
        if (up) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        step <= step + 5'd1;
        if (step == StepW'(CordicSteps - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign zr = z + 34'sd32768;
  assign x_out = x;
  assign y_out = y;
  assign ang_out = zero_vec ? 16'h0000 : zr[31:16];

endmodule

@@ hdl/sdwv_sqrt.sv @@
module sdwv_sqrt import sdwv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem, r, probe, trial;
  logic running;

  assign trial = r + probe;

  // One result bit per cycle, floor square root.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem <= n;
        r <= '0;
        probe <= 64'h4000_0000_0000_0000;
      end else if (running) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          r <= (r >> 1) + probe;
        end else begin
          r <= r >> 1;
        end
        probe <= probe >> 2;
        if (probe[0]) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = r[31:0];

endmodule

@@ hdl/sdwv_mdu.sv @@
module sdwv_mdu import sdwv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [31:0]     mul_a,
  input  logic signed [31:0]     mul_b,
  output logic signed [63:0]     prod,
  input  div_req_t               div_req,
  output logic                   div_done,
  output logic signed [DivW-1:0] quo
);

  logic signed [63:0] p;
  logic [DivW-1:0] dvd;
  logic [7:0] rem, den;
  logic [8:0] sh;
  logic [DivCntW-1:0] cnt;
  logic neg, running, qbit;

  assign p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= p;
  end

  assign sh = {rem, dvd[DivW-1]};
  assign qbit = sh >= {1'b0, den};

  // Restoring division on magnitudes, quotient truncated toward zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (div_req.start) begin
        running <= 1'b1;
        neg <= div_req.num < 0;
        dvd <= (div_req.num < 0) ? DivW'(-div_req.num) : DivW'(div_req.num);
        rem <= '0;
        den <= div_req.den;
        cnt <= '0;
      end else if (running) begin
        rem <= qbit ? 8'(sh - {1'b0, den}) : sh[7:0];
        dvd <= {dvd[DivW-2:0], qbit};
        cnt <= cnt + 6'd1;
        if (cnt == DivCntW'(DivW - 1)) begin
          running <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(dvd) : $signed(dvd);

endmodule

@@ hdl/swerve_drive_wheel_vectors.sv @@
// Swerve drive inverse kinematics. One joystick item (x, y, rotation and gyro
// heading) yields one item of four wheel speeds and headings. Small axis values
// are cut by the dead band, the stick becomes a magnitude capped at 1.0 and an
// angle clockwise from minus y, drive and rotation are shared by the ratio
// register or clamped in post mode, then ramped toward the previous command with
// weight 1/coast_factor (0 acts as 1). In field mode the drive angle is turned by
// the heading. The block handles one item at a time: in_ready is high only while
// idle, and the result holds on the output port until it is taken. An item uses
// one shared 24-step CORDIC (13 passes, 12 for a stationary stick), one
// one-bit-per-cycle square root (6 passes), a 40-bit ramp divider (3 passes)
// and a single registered 32x32 multiplier, all driven by one sequencer.
// Configuration writes are always ready and must be made while idle.
module swerve_drive_wheel_vectors import sdwv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic signed [15:0] rotate_cmd,
  input  logic signed [15:0] heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        front_left_speed,
  output logic [15:0]        front_left_heading,
  output logic [15:0]        front_right_speed,
  output logic [15:0]        front_right_heading,
  output logic [15:0]        back_left_speed,
  output logic [15:0]        back_left_heading,
  output logic [15:0]        back_right_speed,
  output logic [15:0]        back_right_heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Sequencer states. The ROT, VEC and MAG groups are shared routines that
  // return to the state held in ret.
  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_ANG0 = 6'd1;
  localparam logic [5:0] ST_ANGR = 6'd2;
  localparam logic [5:0] ST_SQ1  = 6'd3;
  localparam logic [5:0] ST_SQ2  = 6'd4;
  localparam logic [5:0] ST_SQ3  = 6'd5;
  localparam logic [5:0] ST_SQW  = 6'd6;
  localparam logic [5:0] ST_MIX1 = 6'd7;
  localparam logic [5:0] ST_MIX2 = 6'd8;
  localparam logic [5:0] ST_MIX3 = 6'd9;
  localparam logic [5:0] ST_RI   = 6'd10;
  localparam logic [5:0] ST_RP   = 6'd11;
  localparam logic [5:0] ST_RMP0 = 6'd12;
  localparam logic [5:0] ST_RMPM = 6'd13;
  localparam logic [5:0] ST_RMPD = 6'd14;
  localparam logic [5:0] ST_RMPW = 6'd15;
  localparam logic [5:0] ST_UPD  = 6'd16;
  localparam logic [5:0] ST_UPD2 = 6'd17;
  localparam logic [5:0] ST_UPD3 = 6'd18;
  localparam logic [5:0] ST_DRV  = 6'd19;
  localparam logic [5:0] ST_WHL  = 6'd20;
  localparam logic [5:0] ST_WSUM = 6'd21;
  localparam logic [5:0] ST_WMAG = 6'd22;
  localparam logic [5:0] ST_WANG = 6'd23;
  localparam logic [5:0] ST_OUT  = 6'd24;
  localparam logic [5:0] ROT_M   = 6'd25;
  localparam logic [5:0] ROT_C   = 6'd26;
  localparam logic [5:0] ROT_W   = 6'd27;
  localparam logic [5:0] VEC_S   = 6'd28;
  localparam logic [5:0] VEC_W   = 6'd29;
  localparam logic [5:0] MAG_A   = 6'd30;
  localparam logic [5:0] MAG_B   = 6'd31;
  localparam logic [5:0] MAG_C   = 6'd32;
  localparam logic [5:0] MAG_W   = 6'd33;

  // Configuration registers.
  logic [15:0] drive_turn_ratio;
  logic [7:0] coast_factor;
  logic [14:0] dead_band;
  logic robot_frame_mode, post_clamp_mode;

  // Ramp state carried from one item to the next.
  logic [16:0] prev_drive_mag;
  logic [15:0] prev_drive_angle;
  logic signed [16:0] prev_rotate;

  logic [5:0] state, ret;
  logic [1:0] k, j;

  logic signed [16:0] sx, sy, st, mag, rmag;
  logic [15:0] hd, ang, rang;
  logic signed [31:0] ci, si, cp, sp, cr, sr, dc, ds, vc, vs;
  logic [63:0] acc;
  logic [17:0] mag_res;
  logic [15:0] speed [4];
  logic [15:0] hdg [4];

  // Shared units.
  cordic_req_t cord_req;
  logic cord_done;
  logic signed [VecW-1:0] cord_x, cord_y;
  logic [15:0] cord_ang;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  div_req_t div_req;
  logic div_done;
  logic signed [DivW-1:0] quo;
  logic sq_start, sq_done;
  logic [31:0] sq_root;

  sdwv_cordic u_cordic (
    .clk(clk), .rst(rst), .req(cord_req), .done(cord_done),
    .x_out(cord_x), .y_out(cord_y), .ang_out(cord_ang)
  );

  sdwv_mdu u_mdu (
    .clk(clk), .rst(rst), .mul_a(mul_a), .mul_b(mul_b), .prod(prod),
    .div_req(div_req), .div_done(div_done), .quo(quo)
  );

  sdwv_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .n(acc + 64'(prod)),
    .done(sq_done), .root(sq_root)
  );

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  // Dead band on the incoming axes.
  logic signed [16:0] in_x, in_y, in_t;
  logic [16:0] db17;
  assign db17 = {2'b00, dead_band};
  assign in_x = (abs17(17'(stick_x)) < db17) ? '0 : 17'(stick_x);
  assign in_y = (abs17(17'(stick_y)) < db17) ? '0 : 17'(stick_y);
  assign in_t = (abs17(17'(rotate_cmd)) < db17) ? '0 : 17'(rotate_cmd);

  logic stationary;
  assign stationary = (abs17(sx) <= db17) && (abs17(sy) <= db17);

  logic [7:0] cf;
  assign cf = (coast_factor == 8'd0) ? 8'd1 : coast_factor;

  // Post clamp on doubled values (units of 1/65536).
  logic signed [19:0] m2, t2, m2n, t2n, rr, omr;
  logic signed [16:0] mix_mag, mix_t;
  always_comb begin
    rr = {4'b0000, drive_turn_ratio};
    omr = 20'sd65536 - rr;
    m2 = 20'(mag) <<< 1;
    t2 = 20'(st) <<< 1;
    m2n = m2;
    t2n = t2;
    if (m2 + t2 > 20'sd65536) begin
      if (m2 > rr) m2n = 20'sd65536 - ((t2 < omr) ? t2 : omr);
      if (t2 > omr) t2n = 20'sd65536 - ((m2n < rr) ? m2n : rr);
    end
    mix_mag = 17'(m2n >>> 1);
    mix_t = 17'(t2n >>> 1);
  end

  logic signed [31:0] ramp_prev, ramp_cur;
  always_comb begin
    unique case (j)
      2'd0: begin
        ramp_prev = cp;
        ramp_cur = ci;
      end
      2'd1: begin
        ramp_prev = sp;
        ramp_cur = si;
      end
      default: begin
        ramp_prev = 32'(prev_rotate);
        ramp_cur = 32'(st);
      end
    endcase
  end

  // Multiplier operands by state; the product is read one state later.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ1: begin
        mul_a = 32'(sx);
        mul_b = 32'(sx);
      end
      ST_SQ2: begin
        mul_a = 32'(sy);
        mul_b = 32'(sy);
      end
      ST_MIX1: begin
        mul_a = 32'(mag);
        mul_b = {16'h0000, drive_turn_ratio};
      end
      ST_MIX2: begin
        mul_a = 32'(st);
        mul_b = 32'sd65536 - {16'h0000, drive_turn_ratio};
      end
      ROT_M: begin
        mul_a = 32'(rmag);
        mul_b = {2'b00, CordicGain};
      end
      ST_RMPM: begin
        mul_a = {24'h000000, cf - 8'd1};
        mul_b = ramp_prev;
      end
      MAG_A: begin
        mul_a = vc;
        mul_b = vc;
      end
      MAG_B: begin
        mul_a = vs;
        mul_b = vs;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cord_req.start = (state == ROT_C) || (state == VEC_S);
  assign cord_req.vec_mode = (state == VEC_S);
  assign cord_req.x = (state == ROT_C) ? VecW'(prod >>> 17) : VecW'(vc);
  assign cord_req.y = VecW'(vs);
  assign cord_req.ang = rang;

  assign div_req.start = (state == ST_RMPD);
  assign div_req.num = DivW'(ramp_cur) + DivW'(prod);
  assign div_req.den = cf;

  assign sq_start = (state == ST_SQ3) || (state == MAG_C);

  logic signed [63:0] prod_rnd;
  assign prod_rnd = prod + (prod[63] ? 64'sd65535 : 64'sd0);

  logic [32:0] root_rnd;
  assign root_rnd = {1'b0, sq_root} + 33'd4096;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_turn_ratio <= DriveTurnRatioRst;
      coast_factor <= CoastFactorRst;
      dead_band <= DeadBandRst;
      robot_frame_mode <= 1'b0;
      post_clamp_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegDriveTurnRatio: drive_turn_ratio <= cfg_data;
        RegCoastFactor: coast_factor <= cfg_data[7:0];
        RegDeadBand: dead_band <= cfg_data[14:0];
        RegRobotFrame: robot_frame_mode <= cfg_data[0];
        RegPostClamp: post_clamp_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
      k <= '0;
      j <= '0;
      prev_drive_mag <= '0;
      prev_drive_angle <= '0;
      prev_rotate <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sx <= in_x;
            sy <= in_y;
            st <= in_t;
            hd <= heading;
            state <= ST_ANG0;
          end
        end
        ST_ANG0: begin
          if (stationary) begin
            ang <= '0;
            state <= ST_SQ1;
          end else begin
            vc <= 32'(-sy) <<< 13;
            vs <= 32'(sx) <<< 13;
            ret <= ST_ANGR;
            state <= VEC_S;
          end
        end
        ST_ANGR: begin
          ang <= cord_ang;
          state <= ST_SQ1;
        end
        ST_SQ1: state <= ST_SQ2;
        ST_SQ2: begin
          acc <= 64'(prod);
          state <= ST_SQ3;
        end
        ST_SQ3: state <= ST_SQW;
        ST_SQW: begin
          if (sq_done) begin
            mag <= (sq_root > 32'd32768) ? 17'sd32768 : 17'(sq_root);
            state <= ST_MIX1;
          end
        end
        ST_MIX1: begin
          if (post_clamp_mode) begin
            mag <= mix_mag;
            st <= mix_t;
            state <= ST_RI;
          end else begin
            state <= ST_MIX2;
          end
        end
        ST_MIX2: begin
          mag <= 17'(prod >>> 16);
          state <= ST_MIX3;
        end
        ST_MIX3: begin
          st <= 17'(prod_rnd >>> 16);
          state <= ST_RI;
        end
        ST_RI: begin
          rmag <= mag;
          rang <= ang;
          ret <= ST_RP;
          state <= ROT_M;
        end
        ST_RP: begin
          ci <= 32'(cord_x);
          si <= 32'(cord_y);
          rmag <= $signed(prev_drive_mag);
          rang <= prev_drive_angle;
          ret <= ST_RMP0;
          state <= ROT_M;
        end
        ST_RMP0: begin
          cp <= 32'(cord_x);
          sp <= 32'(cord_y);
          j <= 2'd0;
          state <= ST_RMPM;
        end
        ST_RMPM: state <= ST_RMPD;
        ST_RMPD: state <= ST_RMPW;
        ST_RMPW: begin
          if (div_done) begin
            unique case (j)
              2'd0: cr <= 32'(quo);
              2'd1: sr <= 32'(quo);
              default: begin
                if (quo > 40'sd32768) st <= 17'sd32768;
                else if (quo < -40'sd32768) st <= -17'sd32768;
                else st <= 17'(quo);
              end
            endcase
            if (j == 2'd2) begin
              state <= ST_UPD;
            end else begin
              j <= j + 2'd1;
              state <= ST_RMPM;
            end
          end
        end
        ST_UPD: begin
          vc <= cr;
          vs <= sr;
          ret <= ST_UPD2;
          state <= MAG_A;
        end
        ST_UPD2: begin
          prev_drive_mag <= (mag_res > 18'd32768) ? 17'd32768 : 17'(mag_res);
          ret <= ST_UPD3;
          state <= VEC_S;
        end
        ST_UPD3: begin
          prev_drive_angle <= cord_ang;
          prev_rotate <= st;
          rmag <= $signed(prev_drive_mag);
          rang <= robot_frame_mode ? cord_ang : cord_ang - hd;
          ret <= ST_DRV;
          state <= ROT_M;
        end
        ST_DRV: begin
          dc <= 32'(cord_x);
          ds <= 32'(cord_y);
          k <= 2'd0;
          state <= ST_WHL;
        end
        ST_WHL: begin
          rmag <= st;
          rang <= wheel_angle(k);
          ret <= ST_WSUM;
          state <= ROT_M;
        end
        ST_WSUM: begin
          vc <= 32'(cord_x) + dc;
          vs <= 32'(cord_y) + ds;
          ret <= ST_WMAG;
          state <= MAG_A;
        end
        ST_WMAG: begin
          speed[k] <= (mag_res > 18'd65535) ? 16'hFFFF : mag_res[15:0];
          ret <= ST_WANG;
          state <= VEC_S;
        end
        ST_WANG: begin
          hdg[k] <= cord_ang;
          if (k == 2'd3) begin
            state <= ST_OUT;
          end else begin
            k <= k + 2'd1;
            state <= ST_WHL;
          end
        end
        ST_OUT: begin
          if (out_ready) state <= ST_IDLE;
        end
        ROT_M: state <= ROT_C;
        ROT_C: state <= ROT_W;
        ROT_W: begin
          if (cord_done) state <= ret;
        end
        VEC_S: state <= VEC_W;
        VEC_W: begin
          if (cord_done) state <= ret;
        end
        MAG_A: state <= MAG_B;
        MAG_B: begin
          acc <= 64'(prod);
          state <= MAG_C;
        end
        MAG_C: state <= MAG_W;
        MAG_W: begin
          if (sq_done) begin
            mag_res <= 18'(root_rnd >> 13);
            state <= ret;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  assign front_left_speed = speed[0];
  assign front_left_heading = hdg[0];
  assign front_right_speed = speed[1];
  assign front_right_heading = hdg[1];
  assign back_left_speed = speed[2];
  assign back_left_heading = hdg[2];
  assign back_right_speed = speed[3];
  assign back_right_heading = hdg[3];

  // The stored drive magnitude never exceeds 1.0.
  assert property (@(posedge clk) disable iff (rst) prev_drive_mag <= 17'd32768)
    else $error("stored drive magnitude above one");

  // A result and a new item never meet.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // An accepted item starts the sequence at once.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer did not leave idle");

  // Taking the result frees the block for the next item.
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_ready) |=> in_ready)
    else $error("block not idle after result was taken");

endmodule
